[hw/rtl/cplx_scan_pkg.sv]
// Shared widths, number format helpers and types of the complex 2x2 recurrence scan.
package cplx_scan_pkg;

  localparam int MAX_SERIES = 1024;
  localparam int ADDR_W     = $clog2(MAX_SERIES);
  localparam int SLOT_W     = 10;
  localparam int CW         = 16;
  localparam int FRAC       = CW - 4;
  localparam int WORD_W     = 2 * CW;
  localparam int PAIR_W     = 2 * WORD_W;
  localparam int PROD_W     = 2 * CW;
  localparam int ACC_W      = PROD_W + 3;
  localparam int RND_W      = ACC_W - FRAC;
  localparam int NPROD      = 8;

  typedef logic signed [CW-1:0]     comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [SLOT_W-1:0]        slot_t;

  typedef struct packed {
    logic  clipped;
    comp_t value;
  } rs_t;

  localparam rnd_t R_MAX = rnd_t'((2 ** (CW - 1)) - 1);
  localparam rnd_t R_MIN = rnd_t'(-(2 ** (CW - 1)));
  localparam acc_t HALF  = acc_t'(2 ** (FRAC - 1));

  function automatic comp_t re_of(word_t w);
    re_of = comp_t'(w[WORD_W-1:CW]);
  endfunction

  function automatic comp_t im_of(word_t w);
    im_of = comp_t'(w[CW-1:0]);
  endfunction

  function automatic prod_t smul(comp_t a, comp_t b);
    smul = prod_t'(a) * prod_t'(b);
  endfunction

  // Round to nearest with ties upward, then clip to the component range.
  function automatic rs_t round_sat(acc_t acc);
    acc_t t;
    rnd_t r;
    rs_t  o;
    t = acc + HALF;
    r = rnd_t'(t[ACC_W-1:FRAC]);
    if (r > R_MAX) begin
      o.clipped = 1'b1;
      o.value   = comp_t'(R_MAX[CW-1:0]);
    end else if (r < R_MIN) begin
      o.clipped = 1'b1;
      o.value   = comp_t'(R_MIN[CW-1:0]);
    end else begin
      o.clipped = 1'b0;
      o.value   = comp_t'(r[CW-1:0]);
    end
    round_sat = o;
  endfunction

endpackage

[hw/rtl/cplx_scan_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module cplx_scan_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/complex_two_by_two_recurrence_scan.sv]
// Top level of the complex 2x2 recurrence scan: state memory, multiply stage and sum stage.
// Each request updates one series slot: the slot's stored complex pair is read from an internal
// memory (or taken as zero when in_start_of_sequence is set), multiplied by the 2x2 complex
// coefficient matrix, added to the drive, rounded, saturated, written back and returned.
// A result passes the multiply stage, the sum stage and the output register. Requests are
// accepted one per cycle while out_ready does not stall the output and consecutive requests
// name different slots; a request for the slot of the request accepted just before waits until
// that update is written back, as the new pair is only known after the multiply and sum stages.
// The slot memory holds no defined contents after reset: the first request for each slot must
// have in_start_of_sequence set. Slot numbers address the memory modulo its depth of 1024.
module complex_two_by_two_recurrence_scan import cplx_scan_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_series_slot,
  input  logic        in_start_of_sequence,
  input  logic [31:0] in_coeff_11,
  input  logic [31:0] in_coeff_12,
  input  logic [31:0] in_coeff_21,
  input  logic [31:0] in_coeff_22,
  input  logic [31:0] in_drive_0,
  input  logic [31:0] in_drive_1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_slot_echo,
  output logic [31:0] out_new_state_0,
  output logic [31:0] out_new_state_1,
  output logic        out_saturated_flag
);

  logic              s1_valid_r;
  slot_t             s1_slot_r;
  logic              s1_start_r;
  logic              s1_hit_r;
  word_t             s1_coef_r [4];
  word_t             s1_drive_r [2];

  logic              s2_valid_r;
  slot_t             s2_slot_r;
  prod_t             s2_prod_r [2][NPROD];
  word_t             s2_drive_r [2];

  logic              out_valid_r;
  slot_t             out_slot_r;
  word_t             out_n0_r;
  word_t             out_n1_r;
  logic              out_sat_r;

  logic              en1;
  logic              en2;
  logic              en_out;
  logic              accept;
  logic              hazard;
  logic              wr_en;
  addr_t             in_idx;
  logic [PAIR_W-1:0] rd_data;
  word_t             p0;
  word_t             p1;
  prod_t             prod_nxt [2][NPROD];
  word_t             n0_nxt;
  word_t             n1_nxt;
  logic              sat_nxt;
  acc_t              acc_re;
  acc_t              acc_im;
  rs_t               rs_re;
  rs_t               rs_im;
  word_t             row_w [2];
  logic [1:0]        row_sat;

  assign in_idx = in_series_slot[ADDR_W-1:0];
  assign en_out = !out_valid_r || out_ready;
  assign en2    = !s2_valid_r || en_out;
  assign en1    = !s1_valid_r || en2;
  assign wr_en  = s2_valid_r && en_out;

  // A slot still ahead in the pipe and not written back at this edge must not be read yet.
  assign hazard = (s1_valid_r && (s1_slot_r[ADDR_W-1:0] == in_idx)) ||
                  (s2_valid_r && !en_out && (s2_slot_r[ADDR_W-1:0] == in_idx));
  assign in_ready = en1 && !hazard;
  assign accept   = in_valid && in_ready;

  cplx_scan_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_SERIES)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s2_slot_r[ADDR_W-1:0]),
    .wr_data ({n0_nxt, n1_nxt}),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_slot_r     <= in_series_slot;
      s1_start_r    <= in_start_of_sequence;
      s1_hit_r      <= wr_en && (s2_slot_r[ADDR_W-1:0] == in_idx);
      s1_coef_r[0]  <= in_coeff_11;
      s1_coef_r[1]  <= in_coeff_12;
      s1_coef_r[2]  <= in_coeff_21;
      s1_coef_r[3]  <= in_coeff_22;
      s1_drive_r[0] <= in_drive_0;
      s1_drive_r[1] <= in_drive_1;
    end
  end

  // The output register still holds a pair written back at the edge this request was read.
  always_comb begin
    if (s1_start_r) begin
      p0 = '0;
      p1 = '0;
    end else if (s1_hit_r) begin
      p0 = out_n0_r;
      p1 = out_n1_r;
    end else begin
      p0 = rd_data[PAIR_W-1:WORD_W];
      p1 = rd_data[WORD_W-1:0];
    end
  end

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      prod_nxt[r][0] = smul(re_of(s1_coef_r[2*r]),   re_of(p0));
      prod_nxt[r][1] = smul(im_of(s1_coef_r[2*r]),   im_of(p0));
      prod_nxt[r][2] = smul(re_of(s1_coef_r[2*r+1]), re_of(p1));
      prod_nxt[r][3] = smul(im_of(s1_coef_r[2*r+1]), im_of(p1));
      prod_nxt[r][4] = smul(re_of(s1_coef_r[2*r]),   im_of(p0));
      prod_nxt[r][5] = smul(im_of(s1_coef_r[2*r]),   re_of(p0));
      prod_nxt[r][6] = smul(re_of(s1_coef_r[2*r+1]), im_of(p1));
      prod_nxt[r][7] = smul(im_of(s1_coef_r[2*r+1]), re_of(p1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      s2_slot_r  <= s1_slot_r;
      s2_prod_r  <= prod_nxt;
      s2_drive_r <= s1_drive_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      acc_re = acc_t'(s2_prod_r[r][0]) - acc_t'(s2_prod_r[r][1]) +
               acc_t'(s2_prod_r[r][2]) - acc_t'(s2_prod_r[r][3]) +
               (acc_t'(re_of(s2_drive_r[r])) <<< FRAC);
      acc_im = acc_t'(s2_prod_r[r][4]) + acc_t'(s2_prod_r[r][5]) +
               acc_t'(s2_prod_r[r][6]) + acc_t'(s2_prod_r[r][7]) +
               (acc_t'(im_of(s2_drive_r[r])) <<< FRAC);
      rs_re      = round_sat(acc_re);
      rs_im      = round_sat(acc_im);
      row_w[r]   = {rs_re.value, rs_im.value};
      row_sat[r] = rs_re.clipped || rs_im.clipped;
    end
    n0_nxt  = row_w[0];
    n1_nxt  = row_w[1];
    sat_nxt = |row_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_slot_r <= s2_slot_r;
      out_n0_r   <= n0_nxt;
      out_n1_r   <= n1_nxt;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_slot_echo      = out_slot_r;
  assign out_new_state_0    = out_n0_r;
  assign out_new_state_1    = out_n1_r;
  assign out_saturated_flag = out_sat_r;

  a_no_s1_collision: assert property (@(posedge clk) disable iff (!rst_n)
    accept && s1_valid_r |-> s1_slot_r[ADDR_W-1:0] != in_idx)
    else $error("A request entered behind an unfinished update of the same slot.");

  a_forward_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept && wr_en && (s2_slot_r[ADDR_W-1:0] == in_idx) |=> s1_hit_r && s1_valid_r)
    else $error("A write-back at the read edge was not marked for forwarding.");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !en_out |=> s2_valid_r && $stable(s2_slot_r))
    else $error("The sum stage lost or changed a stalled request.");

  a_write_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_valid_r && (out_slot_r == $past(s2_slot_r)))
    else $error("A write-back did not produce a result.");

endmodule
